/* rtl/ztd_pkg.sv */
package ztd_pkg;

    // Initial key values loaded at reset and on restart.
    localparam logic [31:0] INIT_KEY0 = 32'd305419896;
    localparam logic [31:0] INIT_KEY1 = 32'd591751049;
    localparam logic [31:0] INIT_KEY2 = 32'd878082192;

    // Reflected CRC-32 polynomial and the key one multiplier.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] LCG_MULT = 32'd134775813;

    // Number of decrypted bytes that form the encryption header.
    localparam logic [3:0] HEADER_LEN = 4'd12;

    // Input item kinds.
    localparam logic FUNC_KEY    = 1'b0;
    localparam logic FUNC_CIPHER = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // latch the input item, apply restart
        logic ks;       // keystream byte and plain byte
        logic crc0;     // CRC byte step on key zero
        logic add1;     // key one plus low byte of key zero
        logic mul1;     // key one times multiplier plus one
        logic crc2;     // CRC byte step on key two and load the result
    } ztd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // output register empty or being taken
    } ztd_stat_t;

    // One reflected CRC-32 byte step.
    function automatic logic [31:0] crc_byte_step(input logic [31:0] crc,
                                                  input logic [7:0] b);
        logic [31:0] c;
        c = {24'd0, crc[7:0] ^ b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c ^ (crc >> 8);
    endfunction

endpackage

/* rtl/ztd_ctrl.sv */
module ztd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ztd_pkg::ztd_stat_t  stat,
    output ztd_pkg::ztd_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KS   = 3'd1;
    localparam logic [2:0] ST_CRC0 = 3'd2;
    localparam logic [2:0] ST_ADD1 = 3'd3;
    localparam logic [2:0] ST_MUL1 = 3'd4;
    localparam logic [2:0] ST_CRC2 = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Step through the key update, one stage per cycle, holding in the last stage while the output is not free.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_KS;
                end
            end
            ST_KS:
            begin
                cmd.ks     = 1'b1;
                state_next = ST_CRC0;
            end
            ST_CRC0:
            begin
                cmd.crc0   = 1'b1;
                state_next = ST_ADD1;
            end
            ST_ADD1:
            begin
                cmd.add1   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_CRC2;
            end
            ST_CRC2:
            begin
                // Finish only when the output register can take the result.
                if (stat.out_free)
                begin
                    cmd.crc2   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/ztd_datapath.sv */
module ztd_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ztd_pkg::ztd_cmd_t   cmd,
    output ztd_pkg::ztd_stat_t  stat,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic [1:0]          s_tuser,   // [0] func, [1] restart
    input  logic                s_tlast,   // final_in
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] plain_byte
    output logic                m_tuser,   // [0] in_header
    output logic                m_tlast    // final_out
);

    logic [31:0] key0_reg, key0_next;
    logic [31:0] key1_reg, key1_next;
    logic [31:0] key2_reg, key2_next;
    logic [3:0]  count_reg, count_next;
    logic        func_reg, func_next;
    logic        fin_reg, fin_next;
    logic [7:0]  byte_reg, byte_next;
    logic [7:0]  plain_reg, plain_next;
    logic        hdr_reg, hdr_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_hdr_reg, out_hdr_next;
    logic        out_last_reg, out_last_next;

    logic [15:0] ks_t;
    logic [31:0] ks_prod;
    logic [7:0]  ks_plain;

    // Keystream byte from the low half of key two.
    assign ks_t     = {key2_reg[15:2], 1'b1, key2_reg[0]};
    assign ks_prod  = 32'(ks_t) * 32'(ks_t ^ 16'h0001);
    assign ks_plain = byte_reg ^ ks_prod[15:8];

    assign stat.out_free = !out_valid_reg || m_tready;

    // Key state and per-item working registers.
    always_comb
    begin
        key0_next  = key0_reg;
        key1_next  = key1_reg;
        key2_next  = key2_reg;
        count_next = count_reg;
        func_next  = func_reg;
        fin_next   = fin_reg;
        byte_next  = byte_reg;
        plain_next = plain_reg;
        hdr_next   = hdr_reg;

        if (cmd.accept)
        begin
            func_next = s_tuser[0];
            fin_next  = s_tlast;
            byte_next = s_tdata;
            if (s_tuser[1])
            begin
                key0_next  = ztd_pkg::INIT_KEY0;
                key1_next  = ztd_pkg::INIT_KEY1;
                key2_next  = ztd_pkg::INIT_KEY2;
                count_next = '0;
            end
        end

        if (cmd.ks)
        begin
            if (func_reg == ztd_pkg::FUNC_CIPHER)
            begin
                plain_next = ks_plain;
                byte_next  = ks_plain;
                hdr_next   = (count_reg < ztd_pkg::HEADER_LEN);
                if (count_reg < ztd_pkg::HEADER_LEN)
                begin
                    count_next = count_reg + 4'd1;
                end
            end
            else
            begin
                plain_next = '0;
                hdr_next   = 1'b0;
            end
        end

        if (cmd.crc0)
        begin
            key0_next = ztd_pkg::crc_byte_step(key0_reg, byte_reg);
        end

        if (cmd.add1)
        begin
            key1_next = key1_reg + {24'd0, key0_reg[7:0]};
        end

        if (cmd.mul1)
        begin
            key1_next = (key1_reg * ztd_pkg::LCG_MULT) + 32'd1;
        end

        if (cmd.crc2)
        begin
            key2_next = ztd_pkg::crc_byte_step(key2_reg, key1_reg[31:24]);
        end
    end

    // Output register, loaded when the key update finishes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_hdr_next   = out_hdr_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.crc2)
        begin
            out_valid_next = 1'b1;
            out_data_next  = plain_reg;
            out_hdr_next   = hdr_reg;
            out_last_next  = fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg      <= ztd_pkg::INIT_KEY0;
            key1_reg      <= ztd_pkg::INIT_KEY1;
            key2_reg      <= ztd_pkg::INIT_KEY2;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key0_reg      <= key0_next;
            key1_reg      <= key1_next;
            key2_reg      <= key2_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        fin_reg      <= fin_next;
        byte_reg     <= byte_next;
        plain_reg    <= plain_next;
        hdr_reg      <= hdr_next;
        out_data_reg <= out_data_next;
        out_hdr_reg  <= out_hdr_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hdr_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/zip_traditional_decrypt.sv */
// Traditional ZIP decryption, one byte per item.
// The result is loaded into the output register at the end of the serial key update
// (keystream, CRC on key zero, add and multiply on key one, CRC on key two), which
// waits in its last step while the output is not free; no new item is taken until then.
// Reset: asynchronous active low; keys load their initial constants,
// header count clears and the output register empties.
module zip_traditional_decrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [0] func, [1] restart
    input  logic        s_tlast,   // final_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] plain_byte
    output logic        m_tuser,   // [0] in_header
    output logic        m_tlast    // final_out
);

    ztd_pkg::ztd_cmd_t  cmd;
    ztd_pkg::ztd_stat_t stat;

    // Sequencer for the per-byte key update.
    ztd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Keys, keystream and output register.
    ztd_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
